/* sv/bf_tas_pkg.sv */
// shared types, constants and helpers of the bloom filter test-and-set block
package bf_tas_pkg;

  // filter geometry
  localparam int unsigned FilterWords = 8;
  localparam int unsigned WordIdxW    = $clog2(FilterWords);
  localparam int unsigned BitIdxW     = 5;
  localparam int unsigned PosW        = WordIdxW + BitIdxW;
  localparam int unsigned NumProbes   = 3;
  localparam int unsigned ProbeIdxW   = 2;

  // hash constants
  localparam logic [31:0] StrideSalt = 32'ha5b35705;
  localparam logic [31:0] MixMulA    = 32'h7feb352d;
  localparam logic [31:0] MixMulB    = 32'h846ca68b;
  localparam logic [7:0]  QuadStep   = 8'd17;

  // configuration port
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 32;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_DEVICE_KEY = 1'b0,
    CFG_PACK_KEY   = 1'b1
  } cfg_idx_e;

  // controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BASE_A,
    ST_BASE_B,
    ST_STR_A,
    ST_STR_B,
    ST_PROBE0,
    ST_PROBE1,
    ST_PROBE2,
    ST_RESP
  } state_e;

  // shared multiplier operation
  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_BASE_A,
    MUL_BASE_B,
    MUL_STR_A,
    MUL_STR_B
  } mul_op_e;

  // command bundle from controller to datapath
  typedef struct packed {
    logic                 load;
    mul_op_e              mul_op;
    logic                 probe_en;
    logic [ProbeIdxW-1:0] probe_idx;
  } cmd_t;

  // first xor-shift of the finalizer
  function automatic logic [31:0] xs16(input logic [31:0] x);
    xs16 = x ^ (x >> 16);
  endfunction

  // bit position of probe p: base + p*stride + 17*p*p, low 8 bits
  function automatic logic [PosW-1:0] probe_pos(input logic [PosW-1:0]      base,
                                                input logic [PosW-1:0]      stride,
                                                input logic [ProbeIdxW-1:0] p);
    logic [3:0]      psq;
    logic [PosW-1:0] lin;
    logic [PosW-1:0] quad;
    psq  = {2'b00, p} * {2'b00, p};
    lin  = stride * {{(PosW-ProbeIdxW){1'b0}}, p};
    quad = QuadStep * {4'b0000, psq};
    probe_pos = base + lin + quad;
  endfunction

endpackage

/* sv/bf_tas_ctrl.sv */
// controller state machine: sequences hashing, probing and the result strobe
module bf_tas_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output bf_tas_pkg::cmd_t  cmd_o,
  output logic              busy_o,
  output logic              done_o
);
  import bf_tas_pkg::*;

  state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (start_i) state_d = ST_BASE_A;
      ST_BASE_A: state_d = ST_BASE_B;
      ST_BASE_B: state_d = ST_STR_A;
      ST_STR_A:  state_d = ST_STR_B;
      ST_STR_B:  state_d = ST_PROBE0;
      ST_PROBE0: state_d = ST_PROBE1;
      ST_PROBE1: state_d = ST_PROBE2;
      ST_PROBE2: state_d = ST_RESP;
      ST_RESP:   state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // commands and status
  always_comb begin
    cmd_o.load      = 1'b0;
    cmd_o.mul_op    = MUL_NONE;
    cmd_o.probe_en  = 1'b0;
    cmd_o.probe_idx = '0;
    busy_o          = 1'b1;
    done_o          = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        busy_o     = 1'b0;
        cmd_o.load = start_i;
      end
      ST_BASE_A: cmd_o.mul_op = MUL_BASE_A;
      ST_BASE_B: cmd_o.mul_op = MUL_BASE_B;
      ST_STR_A:  cmd_o.mul_op = MUL_STR_A;
      ST_STR_B:  cmd_o.mul_op = MUL_STR_B;
      ST_PROBE0: begin
        cmd_o.probe_en  = 1'b1;
        cmd_o.probe_idx = ProbeIdxW'(0);
      end
      ST_PROBE1: begin
        cmd_o.probe_en  = 1'b1;
        cmd_o.probe_idx = ProbeIdxW'(1);
      end
      ST_PROBE2: begin
        cmd_o.probe_en  = 1'b1;
        cmd_o.probe_idx = ProbeIdxW'(NumProbes - 1);
      end
      ST_RESP:   done_o = 1'b1;
      default:   busy_o = 1'b1;
    endcase
  end

endmodule

/* sv/bf_tas_dp.sv */
// datapath: key registers, shared hash multiplier and the filter bitmap
module bf_tas_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  bf_tas_pkg::cmd_t                    cmd_i,
  input  logic [31:0]                         peer_id_i,
  input  logic                                cfg_we_i,
  input  logic [bf_tas_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [bf_tas_pkg::CfgDataW-1:0]     cfg_data_i,
  output logic                                is_new_o
);
  import bf_tas_pkg::*;

  logic [31:0] dev_key_q, pack_key_q;
  logic [31:0] base_q, base_d;
  logic [31:0] stride_q, stride_d;
  logic        fresh_q, fresh_d;
  logic [31:0] words_q [FilterWords];

  logic [31:0]         mul_a, mul_k, prod, mixed;
  logic [PosW-1:0]     pos;
  logic [WordIdxW-1:0] widx;
  logic [BitIdxW-1:0]  bidx;
  logic [31:0]         word_rd, word_upd;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_key_q  <= '0;
      pack_key_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_DEVICE_KEY: dev_key_q  <= cfg_data_i;
        CFG_PACK_KEY:   pack_key_q <= cfg_data_i;
        default:        dev_key_q  <= dev_key_q;
      endcase
    end
  end

  // shared multiplier with the xor-shift that follows it
  always_comb begin
    mul_a = base_q;
    mul_k = MixMulA;
    unique case (cmd_i.mul_op)
      MUL_BASE_A: begin mul_a = base_q;   mul_k = MixMulA; end
      MUL_BASE_B: begin mul_a = base_q;   mul_k = MixMulB; end
      MUL_STR_A:  begin mul_a = stride_q; mul_k = MixMulA; end
      MUL_STR_B:  begin mul_a = stride_q; mul_k = MixMulB; end
      default:    begin mul_a = base_q;   mul_k = MixMulA; end
    endcase
    prod = mul_a * mul_k;
    if (cmd_i.mul_op == MUL_BASE_A || cmd_i.mul_op == MUL_STR_A) begin
      mixed = prod ^ (prod >> 15);
    end else begin
      mixed = xs16(prod);
    end
  end

  // hash registers
  always_comb begin
    base_d   = base_q;
    stride_d = stride_q;
    if (cmd_i.load) begin
      base_d   = xs16(peer_id_i ^ dev_key_q);
      stride_d = xs16(peer_id_i ^ pack_key_q ^ StrideSalt);
    end else begin
      unique case (cmd_i.mul_op)
        MUL_BASE_A, MUL_BASE_B: base_d = mixed;
        MUL_STR_A:              stride_d = mixed;
        MUL_STR_B:              stride_d = mixed | 32'd1;
        default:                base_d = base_q;
      endcase
    end
  end

  // probe position and bitmap word access
  assign pos      = probe_pos(base_q[PosW-1:0], stride_q[PosW-1:0], cmd_i.probe_idx);
  assign widx     = pos[PosW-1:BitIdxW];
  assign bidx     = pos[BitIdxW-1:0];
  assign word_rd  = words_q[widx];
  assign word_upd = word_rd | (32'd1 << bidx);

  // new-id flag: any probed bit found clear
  always_comb begin
    fresh_d = fresh_q;
    if (cmd_i.load) begin
      fresh_d = 1'b0;
    end else if (cmd_i.probe_en) begin
      fresh_d = fresh_q | ~word_rd[bidx];
    end
  end

  always_ff @(posedge clk_i) begin
    base_q   <= base_d;
    stride_q <= stride_d;
    fresh_q  <= fresh_d;
  end

  // bitmap, cleared at reset, one bit set per probe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < FilterWords; i++) begin
        words_q[i] <= '0;
      end
    end else if (cmd_i.probe_en) begin
      words_q[widx] <= word_upd;
    end
  end

  assign is_new_o = fresh_q;

endmodule

/* sv/bloom_filter_test_and_set_top.sv */
// top level of the bloom filter test-and-set block
// done_o is raised in RESP, after the hash states and the probe states PROBE0 to PROBE2
// one id at a time: start is taken only in idle; busy is high in every other state
// the four hash multiplies share one 32x32 multiplier, then one probe per cycle
// done_o is a single-cycle strobe; the receiver cannot stall it
// reset clears the bitmap, both keys and the controller asynchronously
module bloom_filter_test_and_set_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic [31:0]                         peer_id_i,
  output logic                                done_o,
  output logic                                is_new_o,
  input  logic                                cfg_we_i,
  input  logic [bf_tas_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [bf_tas_pkg::CfgDataW-1:0]     cfg_data_i
);
  import bf_tas_pkg::*;

  cmd_t cmd;

  // controller
  bf_tas_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .cmd_o   (cmd),
    .busy_o  (busy),
    .done_o  (done_o)
  );

  // datapath
  bf_tas_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .peer_id_i  (peer_id_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .is_new_o   (is_new_o)
  );

`ifndef ASSERT_OFF
  // a transfer in makes the block busy on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("busy not raised after transfer");

  // result strobe follows the transfer in once the hash and probe states are through
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##8 done_o)
    else $error("result strobe missing at fixed latency");

  // strobe only while an item is in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy)
    else $error("result strobe while idle");

  // one strobe per item, then back to idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> (!done_o && !busy))
    else $error("result strobe repeated or block stuck busy");
`endif

endmodule
